/* hw/rtl/pps_pkg.sv */
// Shared constants, types and controller codes for the preemptive priority scheduler.
package pps_pkg;

   // Table geometry and field widths.
   localparam int TABLE_DEPTH = 16;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int PRI_W       = 8;
   localparam int TIME_W      = 16;
   localparam int WAIT_W      = 5;

   // Action codes carried by an input transaction.
   localparam logic ACT_TICK   = 1'b0;
   localparam logic ACT_ARRIVE = 1'b1;

   // One job as held in the table or in the running register.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRI_W-1:0]  pri;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] left;
   } pps_entry_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT
   } pps_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_read;
      logic commit;
   } pps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
   } pps_sts_type;

endpackage

/* hw/rtl/pps_if.sv */
// Request and response channel interfaces of the preemptive priority scheduler.
interface pps_req_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [ID_W-1:0]   job_id;
   logic [PRI_W-1:0]  job_priority;
   logic [TIME_W-1:0] job_start;
   logic [TIME_W-1:0] job_budget;

   modport source (
      output valid, action, job_id, job_priority, job_start, job_budget,
      input  ready
   );
   modport sink (
      input  valid, action, job_id, job_priority, job_start, job_budget,
      output ready
   );
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              running_valid;
   logic [ID_W-1:0]   running_job;
   logic [TIME_W-1:0] running_left;
   logic [WAIT_W-1:0] waiting_count;
   logic              dropped;

   modport source (
      output valid, running_valid, running_job, running_left, waiting_count, dropped,
      input  ready
   );
   modport sink (
      input  valid, running_valid, running_job, running_left, waiting_count, dropped,
      output ready
   );
endinterface

/* hw/rtl/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler.
// A transaction is accepted, then the scan reads one table slot per cycle through a single
// comparator, and the result is committed once the last slot has been compared.
// The result register is loaded at commit; the next transaction is taken only after the
// previous one has committed, and commit stalls while the last result waits.
// Synchronous active-high reset empties the table and clears the running job at once.
module preemptive_priority_scheduler import pps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_if,
   pps_rsp_if.source rsp_if
);

   pps_cmd_type cmd;
   pps_sts_type sts;

   // Control sequencing and handshakes.
   pps_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Table, running job and result register.
   pps_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_if.action),
      .req_job_id        (req_if.job_id),
      .req_job_priority  (req_if.job_priority),
      .req_job_start     (req_if.job_start),
      .req_job_budget    (req_if.job_budget),
      .rsp_running_valid (rsp_if.running_valid),
      .rsp_running_job   (rsp_if.running_job),
      .rsp_running_left  (rsp_if.running_left),
      .rsp_waiting_count (rsp_if.waiting_count),
      .rsp_dropped       (rsp_if.dropped)
   );

endmodule

/* hw/rtl/pps_datapath.sv */
// Datapath: waiting table, running job, slot scan comparator and result register.
module pps_datapath import pps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  pps_cmd_type       cmd,
   output pps_sts_type       sts,
   input  logic              req_action,
   input  logic [ID_W-1:0]   req_job_id,
   input  logic [PRI_W-1:0]  req_job_priority,
   input  logic [TIME_W-1:0] req_job_start,
   input  logic [TIME_W-1:0] req_job_budget,
   output logic              rsp_running_valid,
   output logic [ID_W-1:0]   rsp_running_job,
   output logic [TIME_W-1:0] rsp_running_left,
   output logic [WAIT_W-1:0] rsp_waiting_count,
   output logic              rsp_dropped
);

   // Table storage: payload in a memory, occupancy in flip-flops.
   pps_entry_type            slot_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   slot_valid_ff, slot_valid_in;
   logic [COUNT_W-1:0]       count_ff, count_in;

   // Captured transaction.
   logic                     act_ff;
   pps_entry_type            item_ff;

   // Running job.
   logic                     run_valid_ff, run_valid_in;
   pps_entry_type            run_ff, run_in;

   // Scan pipeline: address counter, registered read and running best.
   logic [SLOT_W-1:0]        idx_ff;
   logic                     rd_act_ff;
   logic                     rd_valid_ff;
   logic [SLOT_W-1:0]        rd_idx_ff;
   pps_entry_type            rd_entry_ff;
   logic                     best_found_ff;
   logic [SLOT_W-1:0]        best_idx_ff;
   pps_entry_type            best_ff;
   logic                     free_found_ff;
   logic [SLOT_W-1:0]        free_idx_ff;
   logic                     better;

   // Commit decisions.
   logic                     run_idle;
   logic                     wr_en;
   pps_entry_type            wr_entry;
   logic                     clr_en;
   logic                     drop;

   // Result register.
   logic                     out_valid_ff;
   logic [ID_W-1:0]          out_job_ff;
   logic [TIME_W-1:0]        out_left_ff;
   logic [WAIT_W-1:0]        out_count_ff;
   logic                     out_drop_ff;

   assign sts.scan_last = (idx_ff == SLOT_W'(TABLE_DEPTH - 1));

   // Capture the accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff        <= req_action;
         item_ff.id    <= req_job_id;
         item_ff.pri   <= req_job_priority;
         item_ff.start <= req_job_start;
         item_ff.left  <= req_job_budget;
      end
   end

   // Table memory: written at commit, read one slot per scan cycle.
   always_ff @(posedge clock) begin
      if (wr_en && cmd.commit) begin
         slot_mem[free_idx_ff] <= wr_entry;
      end
      if (cmd.scan_read) begin
         rd_entry_ff <= slot_mem[idx_ff];
         rd_valid_ff <= slot_valid_ff[idx_ff];
         rd_idx_ff   <= idx_ff;
      end
   end

   // A valid slot beats the best so far on higher priority, then earlier start.
   always_comb begin
      better = !best_found_ff
            || (rd_entry_ff.pri > best_ff.pri)
            || ((rd_entry_ff.pri == best_ff.pri) && (rd_entry_ff.start < best_ff.start));
   end

   // Scan counter, best-candidate and first-free-slot tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         rd_act_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         rd_act_ff <= cmd.scan_read;
         if (cmd.scan_start) begin
            idx_ff        <= '0;
            best_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (cmd.scan_read) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (rd_act_ff) begin
               if (!rd_valid_ff && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= rd_idx_ff;
               end
               if (rd_valid_ff && better) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= rd_idx_ff;
                  best_ff       <= rd_entry_ff;
               end
            end
         end
      end
   end

   // Work out the new running job and table change for this transaction.
   always_comb begin
      run_idle      = !run_valid_ff || (run_ff.left == '0);
      run_valid_in  = run_valid_ff;
      run_in        = run_ff;
      wr_en         = 1'b0;
      wr_entry      = item_ff;
      clr_en        = 1'b0;
      drop          = 1'b0;
      if (act_ff == ACT_ARRIVE) begin
         if (run_idle) begin
            run_valid_in = 1'b1;
            run_in       = item_ff;
         end else if (!free_found_ff) begin
            drop = 1'b1;
         end else if (item_ff.pri > run_ff.pri) begin
            wr_en    = 1'b1;
            wr_entry = run_ff;
            run_in   = item_ff;
         end else begin
            wr_en = 1'b1;
         end
      end else begin
         if (run_idle) begin
            if (best_found_ff) begin
               run_valid_in = 1'b1;
               run_in       = best_ff;
               clr_en       = 1'b1;
            end else begin
               run_valid_in = 1'b0;
            end
         end
         if (run_valid_in && (run_in.left != '0)) begin
            run_in.left = run_in.left - 1'b1;
         end
      end
   end

   // Occupancy bits and count after the commit.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      if (wr_en) begin
         slot_valid_in[free_idx_ff] = 1'b1;
         count_in                   = count_ff + 1'b1;
      end else if (clr_en) begin
         slot_valid_in[best_idx_ff] = 1'b0;
         count_in                   = count_ff - 1'b1;
      end
   end

   // State update at commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
         run_valid_ff  <= 1'b0;
         run_ff        <= '0;
      end else if (cmd.commit) begin
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
         run_valid_ff  <= run_valid_in;
         run_ff        <= run_in;
      end
   end

   // Result register, loaded at commit.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_valid_ff <= run_valid_in;
         out_job_ff   <= run_valid_in ? run_in.id : '0;
         out_left_ff  <= run_valid_in ? run_in.left : '0;
         out_count_ff <= WAIT_W'(count_in);
         out_drop_ff  <= drop;
      end
   end

   assign rsp_running_valid = out_valid_ff;
   assign rsp_running_job   = out_job_ff;
   assign rsp_running_left  = out_left_ff;
   assign rsp_waiting_count = out_count_ff;
   assign rsp_dropped       = out_drop_ff;

endmodule

/* hw/rtl/pps_controller.sv */
// Controller: sequences capture, table scan and commit, and owns the handshakes.
module pps_controller import pps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pps_cmd_type cmd,
   input  pps_sts_type sts
);

   pps_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and response-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Wait until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sim/tb_preemptive_priority_scheduler.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the preemptive priority scheduler, with its scheduling predictor.
module tb_preemptive_priority_scheduler import pps_pkg::*; ;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 6;
   localparam int LATENCY      = TABLE_DEPTH + 4;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 550;

   // One request transaction as the sender drives it.
   typedef struct packed {
      logic              action;
      logic [ID_W-1:0]   job_id;
      logic [PRI_W-1:0]  job_priority;
      logic [TIME_W-1:0] job_start;
      logic [TIME_W-1:0] job_budget;
   } sched_req_type;

   // One status transaction as the block reports it.
   typedef struct packed {
      logic              running_valid;
      logic [ID_W-1:0]   running_job;
      logic [TIME_W-1:0] running_left;
      logic [WAIT_W-1:0] waiting_count;
      logic              dropped;
   } sched_status_type;

   // Stall patterns of the status receiver.
   typedef enum int {
      RX_OPEN,
      RX_ALTERNATE,
      RX_RANDOM,
      RX_BURSTY
   } rx_mode_type;

   // Keeps a private copy of the scheduler state and the queue of expected statuses.
   class sched_scoreboard;
      bit               waiting[TABLE_DEPTH];
      pps_entry_type    slot[TABLE_DEPTH];
      bit               busy;
      pps_entry_type    current;
      sched_status_type expected_status[$];
      int               errors;

      function new();
         busy    = 1'b0;
         current = '0;
         errors  = 0;
         foreach (waiting[i]) waiting[i] = 1'b0;
      endfunction

      // Lowest-numbered free slot, or -1 when the table is full.
      function int first_free();
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (!waiting[i]) return i;
         return -1;
      endfunction

      // Hands the processor to the best waiting job: highest priority, then the
      // earliest start, then the lowest slot. An empty table leaves it idle.
      function void dispatch_best();
         int best;
         best = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!waiting[i]) continue;
            if (best < 0 || slot[i].pri > slot[best].pri ||
                (slot[i].pri == slot[best].pri && slot[i].start < slot[best].start))
               best = i;
         end
         if (best < 0) begin
            busy = 1'b0;
            return;
         end
         busy          = 1'b1;
         current       = slot[best];
         waiting[best] = 1'b0;
      endfunction

      // Advances the scheduler by one accepted request and records the status it must give.
      function void note_request(sched_req_type r);
         pps_entry_type    incoming;
         sched_status_type st;
         int               free_idx;
         int               count;
         bit               lost;
         incoming = '{id: r.job_id, pri: r.job_priority, start: r.job_start,
                      left: r.job_budget};
         lost     = 1'b0;
         if (r.action == ACT_ARRIVE) begin
            // A finished running job counts as idle and is simply discarded.
            if (!busy || current.left == 0) begin
               busy    = 1'b1;
               current = incoming;
            end else begin
               free_idx = first_free();
               if (free_idx < 0) begin
                  lost = 1'b1;
               end else if (incoming.pri > current.pri) begin
                  slot[free_idx]    = current;
                  waiting[free_idx] = 1'b1;
                  current           = incoming;
               end else begin
                  slot[free_idx]    = incoming;
                  waiting[free_idx] = 1'b1;
               end
            end
         end else begin
            if (!busy || current.left == 0) dispatch_best();
            if (busy && current.left != 0) current.left = current.left - 1'b1;
         end
         count = 0;
         foreach (waiting[i]) if (waiting[i]) count++;
         st.running_valid = busy;
         st.running_job   = busy ? current.id : '0;
         st.running_left  = busy ? current.left : '0;
         st.waiting_count = WAIT_W'(count);
         st.dropped       = lost;
         expected_status.push_back(st);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            errors++;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, field, want, seen);
         end
      endfunction

      // Compares a received status with the oldest expectation.
      function void check_response(sched_status_type got);
         sched_status_type want;
         if (expected_status.size() == 0) begin
            errors++;
            $display("%0t ns: status with none expected, expected nothing, actual 0x%0h",
                     $time, got);
            return;
         end
         want = expected_status.pop_front();
         compare_field("running_valid", want.running_valid, got.running_valid);
         compare_field("running_job", want.running_job, got.running_job);
         compare_field("running_left", want.running_left, got.running_left);
         compare_field("waiting_count", want.waiting_count, got.waiting_count);
         compare_field("dropped", want.dropped, got.dropped);
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   pps_req_if       req_ch ();
   pps_rsp_if       rsp_ch ();
   sched_scoreboard sb;
   int              idle_cycles;
   int              rx_cycle;
   int              rx_hold;
   rx_mode_type     rx_mode;

   preemptive_priority_scheduler u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Drives one transaction at the falling edge and waits for the block to take it.
   task automatic send_request(input sched_req_type r);
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.action       <= r.action;
      req_ch.job_id       <= r.job_id;
      req_ch.job_priority <= r.job_priority;
      req_ch.job_start    <= r.job_start;
      req_ch.job_budget   <= r.job_budget;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(r);
   endtask

   // Leaves the request channel idle for a number of cycles, with junk on the payload.
   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_ch.valid        <= 1'b0;
      req_ch.action       <= 1'($urandom);
      req_ch.job_id       <= ID_W'($urandom);
      req_ch.job_priority <= PRI_W'($urandom);
      req_ch.job_start    <= TIME_W'($urandom);
      req_ch.job_budget   <= TIME_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_arrival(input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri,
                               input logic [TIME_W-1:0] start,
                               input logic [TIME_W-1:0] budget);
      send_request('{action: ACT_ARRIVE, job_id: id, job_priority: pri,
                     job_start: start, job_budget: budget});
   endtask

   // A tick carries random content in the fields it ignores.
   task automatic send_tick();
      send_request('{action: ACT_TICK, job_id: ID_W'($urandom),
                     job_priority: PRI_W'($urandom), job_start: TIME_W'($urandom),
                     job_budget: TIME_W'($urandom)});
   endtask

   // Random request. Priorities and starts cluster on a few values so that ties
   // are common; a rare huge budget goes to a priority-zero job so it cannot clog the table.
   function automatic sched_req_type random_job(input int arrive_pct);
      sched_req_type r;
      int            roll;
      r.action       = ($urandom_range(0, 99) < arrive_pct) ? ACT_ARRIVE : ACT_TICK;
      r.job_id       = ID_W'($urandom);
      roll           = $urandom_range(0, 9);
      if (roll < 5)       r.job_priority = PRI_W'($urandom_range(0, 3));
      else if (roll < 8)  r.job_priority = PRI_W'($urandom);
      else if (roll == 8) r.job_priority = '0;
      else                r.job_priority = '1;
      roll = $urandom_range(0, 9);
      if (roll < 5)      r.job_start = TIME_W'($urandom_range(0, 3));
      else if (roll < 9) r.job_start = TIME_W'($urandom);
      else               r.job_start = $urandom_range(0, 1) ? '1 : '0;
      roll = $urandom_range(0, 199);
      if (roll < 3) begin
         r.job_budget   = TIME_W'($urandom);
         r.job_priority = '0;
      end else if (roll < 30) begin
         r.job_budget = '0;
      end else if (roll < 60) begin
         r.job_budget = TIME_W'($urandom_range(0, 40));
      end else begin
         r.job_budget = TIME_W'($urandom_range(1, 6));
      end
      return r;
   endfunction

   // Directed opening: field extremes, preemption, ties, a full table and draining ticks.
   task automatic run_directed();
      send_tick();
      send_arrival(8'h00, 8'h00, 16'h0000, 16'h0000);
      send_arrival(8'hff, 8'h00, 16'hffff, 16'hffff);
      send_arrival(8'h11, 8'hfe, 16'h0000, 16'h0003);
      send_arrival(8'h22, 8'hfe, 16'h0005, 16'h0001);
      send_arrival(8'h33, 8'hfe, 16'h0005, 16'h0002);
      // Fill the table; later slots have earlier starts so the tie-break matters.
      for (int i = 0; i < TABLE_DEPTH - 3; i++)
         send_arrival(ID_W'(8'h40 + i), 8'h80, TIME_W'(16'h0100 - i), TIME_W'(i % 2));
      // Table full: dropped even though it outranks the running job.
      send_arrival(8'hee, 8'hff, 16'h0000, 16'h0007);
      repeat (5) send_tick();
   endtask

   // Random part in bursts with gaps; the arrival share changes by phase so the
   // table both fills up and drains.
   task automatic run_random();
      int sent;
      int burst;
      int phase_left;
      int arrive_pct;
      sent       = 0;
      phase_left = 0;
      arrive_pct = 50;
      while (sent < RANDOM_ITEMS) begin
         if (phase_left <= 0) begin
            case ($urandom_range(0, 3))
               0:       arrive_pct = 15;
               1:       arrive_pct = 45;
               2:       arrive_pct = 70;
               default: arrive_pct = 95;
            endcase
            phase_left = $urandom_range(30, 70);
         end
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            send_request(random_job(arrive_pct));
            sent++;
            phase_left--;
         end
         case ($urandom_range(0, 3))
            0:       ;
            1, 2:    hold_off($urandom_range(1, 4));
            default: hold_off($urandom_range(5, 25));
         endcase
      end
   endtask

   // Receiver stall pattern, reselected at random as rx_cycle advances.
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:      rsp_ch.ready <= 1'b1;
         RX_ALTERNATE: rsp_ch.ready <= (rx_cycle % 2 == 0);
         RX_RANDOM:    rsp_ch.ready <= ($urandom_range(0, 99) < 60);
         default: begin
            if (rx_hold > 0) begin
               rsp_ch.ready <= 1'b0;
               rx_hold--;
            end else begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(5, 30);
            end
         end
      endcase
   end

   // Status checking and the watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response('{running_valid: rsp_ch.running_valid,
                                running_job: rsp_ch.running_job,
                                running_left: rsp_ch.running_left,
                                waiting_count: rsp_ch.waiting_count,
                                dropped: rsp_ch.dropped});
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Main sequence: reset, stimulus, drain, verdict.
   initial begin
      sb                  = new();
      idle_cycles         = 0;
      rx_cycle            = 0;
      rx_hold             = 0;
      rx_mode             = RX_OPEN;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_TICK;
      req_ch.job_id       = '0;
      req_ch.job_priority = '0;
      req_ch.job_start    = '0;
      req_ch.job_budget   = '0;
      rsp_ch.ready        = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.expected_status.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/pps_pkg.sv
hw/rtl/pps_if.sv
hw/rtl/pps_datapath.sv
hw/rtl/pps_controller.sv
hw/rtl/preemptive_priority_scheduler.sv
sim/tb_preemptive_priority_scheduler.sv
